// ===== rtl/lpcd_pkg.sv =====
// shared types, constants and crc step for the length-prefixed crc deframer
package lpcd_pkg;

	// largest payload length the receiver ever accepts
	localparam logic [15:0] MAX_PAYLOAD = 16'd1024;

	// payload limit register
	localparam int unsigned LIMIT_W = 11;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

	// crc-16/modbus constants
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// frame phases
	typedef enum logic [2:0] {
		PH_LEN_LO = 3'd0,
		PH_LEN_HI = 3'd1,
		PH_DATA   = 3'd2,
		PH_CRC_LO = 3'd3,
		PH_CRC_HI = 3'd4
	} phase_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_OK      = 2'd1,
		KIND_LEN_ERR = 2'd2,
		KIND_CRC_ERR = 2'd3
	} kind_t;

	// one result item from the frame decoder
	typedef struct packed {
		logic                valid;
		kind_t               kind;
		logic [7:0]          data_byte;
		logic [LIMIT_W-1:0]  frame_length;
		logic                last;
	} result_t;

	// reflected crc update over one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/lpcd_frame.sv =====
// frame phase tracking, length check and crc compare for one byte per step
module lpcd_frame (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [7:0]                   rx_byte,
	input  logic [lpcd_pkg::LIMIT_W-1:0] payload_limit,
	output lpcd_pkg::result_t            result
);

	lpcd_pkg::phase_t            phase_q, phase_d;
	logic [7:0]                  length_low_q;
	logic [lpcd_pkg::LIMIT_W-1:0] declared_length_q;
	logic [lpcd_pkg::LIMIT_W-1:0] bytes_seen_q;
	logic [15:0]                 crc_q;
	logic [7:0]                  crc_low_q;

	logic [15:0]                 crc_in;
	logic [15:0]                 crc_next;
	logic [15:0]                 len16;
	logic                        len_bad;
	logic [lpcd_pkg::LIMIT_W:0]  seen_inc;
	logic                        data_done;
	logic                        crc_match;

	// shared datapath terms
	assign crc_in    = (phase_q == lpcd_pkg::PH_LEN_HI || phase_q == lpcd_pkg::PH_DATA) ?
	                   crc_q : lpcd_pkg::CRC_INIT;
	assign crc_next  = lpcd_pkg::crc_byte(crc_in, rx_byte);
	assign len16     = {rx_byte, length_low_q};
	assign len_bad   = (len16 == 16'd0) || (len16 > lpcd_pkg::MAX_PAYLOAD) ||
	                   (len16 > {{(16-lpcd_pkg::LIMIT_W){1'b0}}, payload_limit});
	assign seen_inc  = {1'b0, bytes_seen_q} + {{lpcd_pkg::LIMIT_W{1'b0}}, 1'b1};
	assign data_done = seen_inc >= {1'b0, declared_length_q};
	assign crc_match = {rx_byte, crc_low_q} == crc_q;

	// next phase
	always_comb begin
		unique case (phase_q)
			lpcd_pkg::PH_LEN_HI: phase_d = len_bad ? lpcd_pkg::PH_LEN_LO : lpcd_pkg::PH_DATA;
			lpcd_pkg::PH_DATA:   phase_d = data_done ? lpcd_pkg::PH_CRC_LO : lpcd_pkg::PH_DATA;
			lpcd_pkg::PH_CRC_LO: phase_d = lpcd_pkg::PH_CRC_HI;
			lpcd_pkg::PH_CRC_HI: phase_d = lpcd_pkg::PH_LEN_LO;
			default:             phase_d = lpcd_pkg::PH_LEN_HI;
		endcase
	end

	// result for the current byte
	always_comb begin
		result              = '0;
		result.kind         = lpcd_pkg::KIND_DATA;
		unique case (phase_q)
			lpcd_pkg::PH_LEN_HI: begin
				result.valid = len_bad;
				result.kind  = lpcd_pkg::KIND_LEN_ERR;
				result.last  = 1'b1;
			end
			lpcd_pkg::PH_DATA: begin
				result.valid     = 1'b1;
				result.data_byte = rx_byte;
			end
			lpcd_pkg::PH_CRC_HI: begin
				result.valid = 1'b1;
				result.last  = 1'b1;
				if (crc_match) begin
					result.kind         = lpcd_pkg::KIND_OK;
					result.frame_length = declared_length_q;
				end else begin
					result.kind = lpcd_pkg::KIND_CRC_ERR;
				end
			end
			default: result.valid = 1'b0;
		endcase
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= lpcd_pkg::PH_LEN_LO;
			length_low_q      <= '0;
			declared_length_q <= '0;
			bytes_seen_q      <= '0;
			crc_q             <= lpcd_pkg::CRC_INIT;
			crc_low_q         <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			unique case (phase_q)
				lpcd_pkg::PH_LEN_HI: begin
					crc_q        <= len_bad ? lpcd_pkg::CRC_INIT : crc_next;
					bytes_seen_q <= '0;
					if (!len_bad) begin
						declared_length_q <= len16[lpcd_pkg::LIMIT_W-1:0];
					end
				end
				lpcd_pkg::PH_DATA: begin
					crc_q        <= crc_next;
					bytes_seen_q <= seen_inc[lpcd_pkg::LIMIT_W-1:0];
				end
				lpcd_pkg::PH_CRC_LO: begin
					crc_low_q <= rx_byte;
				end
				lpcd_pkg::PH_CRC_HI: begin
					crc_q        <= lpcd_pkg::CRC_INIT;
					bytes_seen_q <= '0;
				end
				default: begin
					length_low_q <= rx_byte;
					crc_q        <= crc_next;
					bytes_seen_q <= '0;
				end
			endcase
		end
	end

endmodule

// ===== rtl/length_prefixed_crc_deframer.sv =====
// top level of the length-prefixed crc-16/modbus deframer
//
// s_axis carries the received byte stream, one byte per transaction.
// m_axis carries results: a payload byte (kind data) for each payload byte
// as it arrives, and one status transaction with tlast high that closes a
// frame: frame ok with the payload length, crc mismatch, or length error.
// The length low byte, an accepted length high byte and the crc low byte give no result.
// payload_limit_we / payload_limit_wdata write the payload limit register;
// write it only while no byte is in flight.
// A result passes through the input register and then the output register
// on its way to m_axis, where it is held until taken.
// Throughput: one byte per cycle while m_axis does not stall, set by the
// combinational crc byte update between the input and output registers.
// Reset clears the valid flags of both registers, returns the decoder to
// expecting a length low byte with the crc at 0xFFFF, and sets the limit to 1024.
// When m_axis stalls, the output register holds its result and the input
// register still takes one more byte if empty, after which s_axis_tready drops.
module length_prefixed_crc_deframer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         payload_limit_we,
	input  logic [lpcd_pkg::LIMIT_W-1:0] payload_limit_wdata,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,   // rx_byte[7:0]
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [23:0]                  m_axis_tdata,   // data_byte[7:0], frame_length[18:8], zero
	output logic [1:0]                   m_axis_tuser,   // kind[1:0]
	output logic                         m_axis_tlast    // last
);

	logic [lpcd_pkg::LIMIT_W-1:0] payload_limit_q;
	logic                         valid_s1;
	logic [7:0]                   byte_s1;
	logic                         out_valid_q;
	lpcd_pkg::result_t            out_q;
	lpcd_pkg::result_t            result;
	logic                         advance;
	logic                         step;

	// handshake control
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign step          = valid_s1 && advance;

	// payload limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_limit_q <= lpcd_pkg::LIMIT_RESET;
		end else if (payload_limit_we) begin
			payload_limit_q <= payload_limit_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// frame decoder
	lpcd_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.rx_byte       (byte_s1),
		.payload_limit (payload_limit_q),
		.result        (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && result.valid) begin
			out_q <= result;
		end
	end

	// master side
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_q.frame_length, out_q.data_byte};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.last;

endmodule
